// ----- design/lcdnw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

  // One input word: what to send to the display.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       line;
  } in_word_t;

  // One output word: a pin state and how long it is held.
  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [3:0] data_nibble;
    logic [7:0] hold_ms;
    logic       last;
  } out_word_t;

  // Opcodes of the input word.
  localparam logic [1:0] OP_CMD      = 2'd0;
  localparam logic [1:0] OP_DATA     = 2'd1;
  localparam logic [1:0] OP_CURSOR   = 2'd2;
  localparam logic [1:0] OP_POWER_UP = 2'd3;

  // Register indexes of the configuration port.
  localparam logic REG_ENABLE_HOLD   = 1'b0;
  localparam logic REG_POWER_UP_WAIT = 1'b1;

  localparam logic [7:0] ENABLE_HOLD_RESET   = 8'd2;
  localparam logic [7:0] POWER_UP_WAIT_RESET = 8'd50;

  // Microprogram geometry.
  localparam int unsigned PcW          = 4;
  localparam int unsigned NumInitCmds  = 6;
  localparam int unsigned IdxW         = $clog2(NumInitCmds);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NumInitCmds - 1);

  // Entry points of the microprogram.
  localparam logic [PcW-1:0] PC_BYTE      = 4'd0;
  localparam logic [PcW-1:0] PC_POWER_UP  = 4'd4;
  localparam logic [PcW-1:0] PC_INIT_LOOP = 4'd5;

  typedef enum logic {
    SRC_ITEM,
    SRC_INIT
  } byte_src_e;

  typedef enum logic [1:0] {
    NIB_HI,
    NIB_LO,
    NIB_ZERO
  } nib_sel_e;

  typedef enum logic [1:0] {
    HOLD_ENABLE,
    HOLD_ZERO,
    HOLD_POWER_UP,
    HOLD_INIT
  } hold_sel_e;

  typedef enum logic [1:0] {
    FLOW_NEXT,
    FLOW_END,
    FLOW_LOOP
  } flow_e;

  // One control word of the microprogram.
  typedef struct packed {
    byte_src_e      src;
    nib_sel_e       nib;
    logic           enable;
    hold_sel_e      hold;
    flow_e          flow;
    logic [PcW-1:0] target;
  } ucode_t;

  // Control from the sequencer to the datapath for one cycle.
  typedef struct packed {
    logic            load;
    logic            fire;
    logic            last;
    ucode_t          cw;
    logic [IdxW-1:0] idx;
  } step_t;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  // Control store. A byte write is four steps; the power-up program
  // emits one idle state and then loops over the init command table.
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    w = '{src: SRC_ITEM, nib: NIB_ZERO, enable: 1'b0, hold: HOLD_ZERO,
          flow: FLOW_END, target: PC_BYTE};
    case (pc)
      4'd0: w = '{SRC_ITEM, NIB_HI,   1'b1, HOLD_ENABLE,   FLOW_NEXT, PC_BYTE};
      4'd1: w = '{SRC_ITEM, NIB_HI,   1'b0, HOLD_ZERO,     FLOW_NEXT, PC_BYTE};
      4'd2: w = '{SRC_ITEM, NIB_LO,   1'b1, HOLD_ENABLE,   FLOW_NEXT, PC_BYTE};
      4'd3: w = '{SRC_ITEM, NIB_LO,   1'b0, HOLD_ZERO,     FLOW_END,  PC_BYTE};
      4'd4: w = '{SRC_ITEM, NIB_ZERO, 1'b0, HOLD_POWER_UP, FLOW_NEXT, PC_BYTE};
      4'd5: w = '{SRC_INIT, NIB_HI,   1'b1, HOLD_ENABLE,   FLOW_NEXT, PC_BYTE};
      4'd6: w = '{SRC_INIT, NIB_HI,   1'b0, HOLD_ZERO,     FLOW_NEXT, PC_BYTE};
      4'd7: w = '{SRC_INIT, NIB_LO,   1'b1, HOLD_ENABLE,   FLOW_NEXT, PC_BYTE};
      4'd8: w = '{SRC_INIT, NIB_LO,   1'b0, HOLD_INIT,     FLOW_LOOP, PC_INIT_LOOP};
      default: w = '{SRC_ITEM, NIB_ZERO, 1'b0, HOLD_ZERO,  FLOW_END,  PC_BYTE};
    endcase
    return w;
  endfunction

  // Power-up command bytes.
  function automatic logic [7:0] init_cmd(logic [IdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Wait in ms after each power-up command.
  function automatic logic [7:0] init_wait(logic [IdxW-1:0] idx);
    logic [7:0] w;
    case (idx)
      3'd0:    w = 8'd1;
      3'd1:    w = 8'd1;
      3'd2:    w = 8'd1;
      3'd3:    w = 8'd20;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/lcdnw_useq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_useq
  import lcdnw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  input  logic       out_free_i,
  output logic       in_stall_o,
  output step_t      step_o
);

  logic            busy_q, busy_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  ucode_t          cw;
  logic            fire;
  logic            last;
  logic            accept;

  // Fetch the current control word and decide whether it ends the program.
  assign cw   = ucode_rom(pc_q);
  assign last = (cw.flow == FLOW_END) || ((cw.flow == FLOW_LOOP) && (idx_q == LastIdx));
  assign fire = busy_q && out_free_i;

  // A new word is taken when idle or in the cycle the final step issues.
  assign in_stall_o = busy_q && !(fire && last);
  assign accept     = in_valid_i && !in_stall_o;

  // Step counter and loop counter.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    idx_d  = idx_q;
    if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        case (cw.flow)
          FLOW_NEXT: begin
            pc_d = pc_q + 1'b1;
          end
          FLOW_LOOP: begin
            pc_d  = cw.target;
            idx_d = idx_q + 1'b1;
          end
          default: begin
            busy_d = 1'b0;
          end
        endcase
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = (opcode_i == OP_POWER_UP) ? PC_POWER_UP : PC_BYTE;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_BYTE;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      idx_q  <= idx_d;
    end
  end

  assign step_o = '{load: accept, fire: fire, last: last, cw: cw, idx: idx_q};

endmodule

`default_nettype wire

// ----- design/lcdnw_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_dpath
  import lcdnw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  step_t     step_i,
  input  logic [7:0] enable_hold_ms_i,
  input  logic [7:0] power_up_wait_ms_i,
  input  logic      out_stall_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  output out_word_t out_data_o
);

  logic [7:0] byte_q;
  logic       rs_q;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [3:0] nibble;
  logic [7:0] hold;
  out_word_t  word;
  logic       out_valid_q;
  out_word_t  out_data_q;

  // Capture the byte to send; a cursor move is 0x80 plus the address.
  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      if (in_data_i.opcode == OP_CURSOR) begin
        byte_q <= CMD_SET_DDRAM | {1'b0, in_data_i.line, in_data_i.column};
      end else begin
        byte_q <= in_data_i.byte_value;
      end
      rs_q <= (in_data_i.opcode == OP_DATA);
    end
  end

  // Byte source: the captured word or the power-up table.
  assign cur_byte = (step_i.cw.src == SRC_INIT) ? init_cmd(step_i.idx) : byte_q;
  assign cur_rs   = (step_i.cw.src == SRC_INIT) ? 1'b0 : rs_q;

  // Nibble and hold time selection from the control word.
  always_comb begin
    case (step_i.cw.nib)
      NIB_HI:  nibble = cur_byte[7:4];
      NIB_LO:  nibble = cur_byte[3:0];
      default: nibble = 4'h0;
    endcase
    case (step_i.cw.hold)
      HOLD_ENABLE:   hold = enable_hold_ms_i;
      HOLD_POWER_UP: hold = power_up_wait_ms_i;
      HOLD_INIT:     hold = init_wait(step_i.idx);
      default:       hold = 8'd0;
    endcase
  end

  assign word = '{reg_select: cur_rs & (step_i.cw.nib != NIB_ZERO),
                  enable: step_i.cw.enable, data_nibble: nibble,
                  hold_ms: hold, last: step_i.last};

  // Output register: free when empty or when its word is taken.
  assign out_free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.fire) begin
      out_data_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- design/char_lcd_nibble_write_sequencer.sv -----
// Character LCD write sequencer for a controller on a 4-bit data bus.
// The input channel takes one word per operation: a command byte, a data
// byte, a cursor move (column and line) or the power-up sequence. The output
// channel gives one word per pin state: register select, enable, the four
// data pins and the time in ms the state is to be held; last marks the final
// state of an operation. Byte operations give four words, power-up gives 25.
// A small microprogram in a read-only control store walks the steps; the
// power-up commands come from a table stepped by a loop counter.
// After acceptance the step counter is loaded, and the first output word is
// then captured in the output register. One output word is issued per cycle
// while the receiver keeps stall low; the next input word is accepted in the
// cycle the final step issues. A stall on the output holds the output
// register and freezes the step counter. The APB port sets the enable hold
// (address 0) and the power-up wait (address 4); write them only while idle.
// Reset returns the sequencer to idle and the registers to 2 ms and 50 ms.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_write_sequencer
  import lcdnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] enable_hold_q;
  logic [7:0] power_up_wait_q;
  logic       cfg_write;
  logic       out_free;
  step_t      step;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_hold_q   <= ENABLE_HOLD_RESET;
      power_up_wait_q <= POWER_UP_WAIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_ENABLE_HOLD) begin
        enable_hold_q <= pwdata[7:0];
      end else begin
        power_up_wait_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_POWER_UP_WAIT) ? {24'd0, power_up_wait_q}
                                                  : {24'd0, enable_hold_q};

  lcdnw_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_data_i.opcode),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .step_o     (step)
  );

  lcdnw_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_data_i          (in_data_i),
    .step_i             (step),
    .enable_hold_ms_i   (enable_hold_q),
    .power_up_wait_ms_i (power_up_wait_q),
    .out_stall_i        (out_stall_i),
    .out_free_o         (out_free),
    .out_valid_o        (out_valid_o),
    .out_data_o         (out_data_o)
  );

endmodule

`default_nettype wire
